>>> sv/pslc_pkg.sv
`timescale 1ns / 1ps
// pslc_pkg: shared types, codes and sizes of the per-source limited cookie table
// no dependencies

package pslc_pkg;

   localparam int PSLC_ENTRIES = 64;

   localparam int OP_WIDTH     = 2;
   localparam int STATUS_WIDTH = 2;
   localparam int COUNT_WIDTH  = 7;
   localparam int WORD_WIDTH   = 64;
   localparam int PORT_WIDTH   = 16;
   localparam int REQ_DATA_WIDTH = 464;
   localparam int RSP_DATA_WIDTH = 272;

   localparam logic [COUNT_WIDTH-1:0] MAX_PER_SOURCE_RESET = 7'd4;
   localparam logic [COUNT_WIDTH-1:0] COUNT_SATURATED     = 7'h7f;

   localparam logic [OP_WIDTH-1:0] OP_ASSIGN = 2'd0;
   localparam logic [OP_WIDTH-1:0] OP_TAKE   = 2'd1;
   localparam logic [OP_WIDTH-1:0] OP_PURGE  = 2'd2;

   localparam logic [STATUS_WIDTH-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] ST_REFUSED   = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] ST_FULL      = 2'd2;
   localparam logic [STATUS_WIDTH-1:0] ST_NOT_FOUND = 2'd3;

   typedef logic [3:0][WORD_WIDTH-1:0] cookie_type;

   typedef struct packed {
      logic [WORD_WIDTH-1:0] ip_high;
      logic [WORD_WIDTH-1:0] ip_low;
      logic [PORT_WIDTH-1:0] port;
   } key_type;

   typedef struct packed {
      key_type               key;
      logic [WORD_WIDTH-1:0] created;
   } entry_type;

   localparam int ENTRY_WIDTH  = $bits(entry_type);
   localparam int COOKIE_WIDTH = $bits(cookie_type);

   typedef struct packed {
      logic [OP_WIDTH-1:0]   opcode;
      key_type               key;
      cookie_type            cookie;
      logic [WORD_WIDTH-1:0] time_value;
   } req_type;

   typedef struct packed {
      logic ip_match;
      logic ep_match;
      logic older;
   } match_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_FINISH
   } state_type;

endpackage

>>> sv/pslc_ram.sv
`timescale 1ns / 1ps
// pslc_ram: generic single write port ram with registered read
// no dependencies

module pslc_ram #(
   parameter int WIDTH      = 64,
   parameter int DEPTH      = 64,
   parameter int ADDR_WIDTH = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [ADDR_WIDTH-1:0] wr_addr,
   input  logic [WIDTH-1:0]      wr_data,
   input  logic [ADDR_WIDTH-1:0] rd_addr,
   output logic [WIDTH-1:0]      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/pslc_match.sv
`timescale 1ns / 1ps
// pslc_match: shared compare unit applied to one table entry per cycle
// depends on pslc_pkg

module pslc_match
   import pslc_pkg::*;
(
   input  logic                  entry_valid,
   input  entry_type             entry,
   input  key_type               key,
   input  logic [WORD_WIDTH-1:0] cutoff,
   output match_type             match
);

   always_comb begin
      match.ip_match = entry_valid && (entry.key.ip_high == key.ip_high)
                       && (entry.key.ip_low == key.ip_low);
      match.ep_match = match.ip_match && (entry.key.port == key.port);
      match.older    = entry_valid && (entry.created < cutoff);
   end

endmodule

>>> sv/per_source_limited_cookie_table.sv
`timescale 1ns / 1ps
// per_source_limited_cookie_table: endpoint keyed cookie table with per-address limit
// depends on pslc_pkg, pslc_ram, pslc_match
//
//  channel | direction | handshake                | payload
//  req     | in        | req_tvalid / req_tready  | tuser opcode, tdata endpoint, cookie, time
//  rsp     | out       | rsp_tvalid / rsp_tready  | tuser status, tdata cookie and counts
//  csr     | in        | csr_we                   | csr_wdata max_per_source
//
// every transaction runs through the accept step, one pass over the entry rams, a drain
// step for the ram read latency and the commit step; the pass feeds the single compare unit
// one entry at a time; after reset a clearing pass empties the valid ram, req_tready low
// a stalled rsp holds the block in its commit step; the next req transaction is taken
// while a finished response still waits

module per_source_limited_cookie_table
   import pslc_pkg::*;
#(
   parameter int ENTRIES = PSLC_ENTRIES
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // ip_high, ip_low, port, random_w0, random_w1, random_w2, random_w3, time_value
   input  logic [REQ_DATA_WIDTH-1:0] req_tdata,
   // opcode
   input  logic [OP_WIDTH-1:0]       req_tuser,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // cookie_w0, cookie_w1, cookie_w2, cookie_w3, purged_count, live_count, zero pad
   output logic [RSP_DATA_WIDTH-1:0] rsp_tdata,
   // status
   output logic [STATUS_WIDTH-1:0]   rsp_tuser,
   input  logic                      csr_we,
   input  logic [COUNT_WIDTH-1:0]    csr_wdata
);

   localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

   state_type              state_ff, state_in;
   logic [IW-1:0]          idx_ff, idx_in;
   logic                   eval_ff, eval_in;
   logic [IW-1:0]          eval_idx_ff, eval_idx_in;
   req_type                req_ff, req_in;
   logic [COUNT_WIDTH-1:0] max_ff, max_in;
   logic [COUNT_WIDTH-1:0] live_ff, live_in;

   logic [COUNT_WIDTH-1:0] same_ip_ff, same_ip_in;
   logic [COUNT_WIDTH-1:0] purged_ff, purged_in;
   logic                   found_ff, found_in;
   logic [IW-1:0]          found_idx_ff, found_idx_in;
   logic                   free_ff, free_in;
   logic [IW-1:0]          free_idx_ff, free_idx_in;
   cookie_type             taken_ff, taken_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [STATUS_WIDTH-1:0] rsp_status_ff, rsp_status_in;
   cookie_type              rsp_cookie_ff, rsp_cookie_in;
   logic [COUNT_WIDTH-1:0]  rsp_purged_ff, rsp_purged_in;
   logic [COUNT_WIDTH-1:0]  rsp_live_ff, rsp_live_in;

   logic          vld_we, vld_wdata, vld_rdata;
   logic [IW-1:0] vld_waddr;
   logic          ent_we;
   logic [IW-1:0] ent_waddr;
   entry_type     ent_wdata, ent_rdata;
   cookie_type    ck_rdata;
   match_type     match;
   logic          out_free;

   pslc_ram #(.WIDTH(1), .DEPTH(ENTRIES), .ADDR_WIDTH(IW)) u_valid_ram (
      .clock   (clock),
      .wr_en   (vld_we),
      .wr_addr (vld_waddr),
      .wr_data (vld_wdata),
      .rd_addr (idx_ff),
      .rd_data (vld_rdata)
   );

   pslc_ram #(.WIDTH(ENTRY_WIDTH), .DEPTH(ENTRIES), .ADDR_WIDTH(IW)) u_entry_ram (
      .clock   (clock),
      .wr_en   (ent_we),
      .wr_addr (ent_waddr),
      .wr_data (ent_wdata),
      .rd_addr (idx_ff),
      .rd_data (ent_rdata)
   );

   pslc_ram #(.WIDTH(COOKIE_WIDTH), .DEPTH(ENTRIES), .ADDR_WIDTH(IW)) u_cookie_ram (
      .clock   (clock),
      .wr_en   (ent_we),
      .wr_addr (ent_waddr),
      .wr_data (req_ff.cookie),
      .rd_addr (idx_ff),
      .rd_data (ck_rdata)
   );

   pslc_match u_match (
      .entry_valid (vld_rdata),
      .entry       (ent_rdata),
      .key         (req_ff.key),
      .cutoff      (req_ff.time_value),
      .match       (match)
   );

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign ent_wdata = '{key: req_ff.key, created: req_ff.time_value};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         idx_ff       <= '0;
         eval_ff      <= 1'b0;
         max_ff       <= MAX_PER_SOURCE_RESET;
         live_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         eval_ff      <= eval_in;
         max_ff       <= max_in;
         live_ff      <= live_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      eval_idx_ff   <= eval_idx_in;
      req_ff        <= req_in;
      same_ip_ff    <= same_ip_in;
      purged_ff     <= purged_in;
      found_ff      <= found_in;
      found_idx_ff  <= found_idx_in;
      free_ff       <= free_in;
      free_idx_ff   <= free_idx_in;
      taken_ff      <= taken_in;
      rsp_status_ff <= rsp_status_in;
      rsp_cookie_ff <= rsp_cookie_in;
      rsp_purged_ff <= rsp_purged_in;
      rsp_live_ff   <= rsp_live_in;
   end

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      eval_in       = 1'b0;
      eval_idx_in   = idx_ff;
      req_in        = req_ff;
      max_in        = csr_we ? csr_wdata : max_ff;
      live_in       = live_ff;
      same_ip_in    = same_ip_ff;
      purged_in     = purged_ff;
      found_in      = found_ff;
      found_idx_in  = found_idx_ff;
      free_in       = free_ff;
      free_idx_in   = free_idx_ff;
      taken_in      = taken_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_cookie_in = rsp_cookie_ff;
      rsp_purged_in = rsp_purged_ff;
      rsp_live_in   = rsp_live_ff;
      req_tready    = 1'b0;
      vld_we        = 1'b0;
      vld_waddr     = idx_ff;
      vld_wdata     = 1'b0;
      ent_we        = 1'b0;
      ent_waddr     = free_idx_ff;

      // one entry per cycle through the compare unit
      if (eval_ff) begin
         if (match.ip_match && (same_ip_ff != COUNT_SATURATED)) begin
            same_ip_in = same_ip_ff + 1'b1;
         end
         if (match.ep_match && !found_ff) begin
            found_in     = 1'b1;
            found_idx_in = eval_idx_ff;
            taken_in     = ck_rdata;
         end
         if (!vld_rdata && !free_ff) begin
            free_in     = 1'b1;
            free_idx_in = eval_idx_ff;
         end
         if ((req_ff.opcode == OP_PURGE) && match.older) begin
            vld_we    = 1'b1;
            vld_waddr = eval_idx_ff;
            purged_in = purged_ff + 1'b1;
         end
      end

      unique case (state_ff)
         ST_CLEAR: begin
            vld_we = 1'b1;
            if (idx_ff == LAST_IDX) begin
               idx_in   = '0;
               state_in = ST_IDLE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               req_in.opcode       = req_tuser;
               req_in.key.ip_high  = req_tdata[63:0];
               req_in.key.ip_low   = req_tdata[127:64];
               req_in.key.port     = req_tdata[143:128];
               req_in.cookie[0]    = req_tdata[207:144];
               req_in.cookie[1]    = req_tdata[271:208];
               req_in.cookie[2]    = req_tdata[335:272];
               req_in.cookie[3]    = req_tdata[399:336];
               req_in.time_value   = req_tdata[463:400];
               idx_in     = '0;
               same_ip_in = '0;
               purged_in  = '0;
               found_in   = 1'b0;
               free_in    = 1'b0;
               state_in   = ST_SCAN;
            end
         end
         ST_SCAN: begin
            eval_in = 1'b1;
            if (idx_ff == LAST_IDX) begin
               state_in = ST_DRAIN;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_OK;
               rsp_cookie_in = '0;
               rsp_purged_in = '0;
               rsp_live_in   = live_ff;
               unique case (req_ff.opcode)
                  OP_ASSIGN: begin
                     if ((same_ip_ff >= max_ff) || found_ff) begin
                        rsp_status_in = ST_REFUSED;
                     end else if (!free_ff) begin
                        rsp_status_in = ST_FULL;
                     end else begin
                        ent_we        = 1'b1;
                        vld_we        = 1'b1;
                        vld_waddr     = free_idx_ff;
                        vld_wdata     = 1'b1;
                        rsp_cookie_in = req_ff.cookie;
                        live_in       = live_ff + 1'b1;
                        rsp_live_in   = live_ff + 1'b1;
                     end
                  end
                  OP_TAKE: begin
                     if (!found_ff) begin
                        rsp_status_in = ST_NOT_FOUND;
                     end else begin
                        vld_we        = 1'b1;
                        vld_waddr     = found_idx_ff;
                        rsp_cookie_in = taken_ff;
                        live_in       = live_ff - 1'b1;
                        rsp_live_in   = live_ff - 1'b1;
                     end
                  end
                  OP_PURGE: begin
                     rsp_purged_in = purged_ff;
                     live_in       = live_ff - purged_ff;
                     rsp_live_in   = live_ff - purged_ff;
                  end
                  default: begin
                  end
               endcase
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {2'b00, rsp_live_ff, rsp_purged_ff, rsp_cookie_ff};

endmodule

>>> sv/pslc_checker.sv
`timescale 1ns / 1ps
// pslc_checker: port level assertions for the cookie table, bound to the top level
// depends on pslc_pkg and per_source_limited_cookie_table

module pslc_checker
   import pslc_pkg::*;
(
   input logic                      clock,
   input logic                      reset,
   input logic                      req_tvalid,
   input logic                      req_tready,
   input logic                      rsp_tvalid,
   input logic                      rsp_tready,
   input logic [RSP_DATA_WIDTH-1:0] rsp_tdata,
   input logic [STATUS_WIDTH-1:0]   rsp_tuser
);

   // clearing pass follows reset
   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> !req_tready)
      else $error("req_tready high right after reset");

   // one transaction at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("req_tready high right after a transaction");

   // refused, full and not found carry no cookie
   a_no_cookie_on_error: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != ST_OK) |-> (rsp_tdata[255:0] == '0))
      else $error("cookie bits set on a failed transaction");

   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("rsp_tvalid dropped while stalled");

endmodule

bind per_source_limited_cookie_table pslc_checker u_pslc_checker (.*);
